### sv/dspm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual sensor pedal map check - shared package
// Field widths, register indexes, error and check type codes, item types and
// the small helper functions used by the range check and the comparison.
// ----------------------------------------------------------------------------
package dspm_pkg;

  // Field widths.
  localparam int unsigned VAL_W     = 16;   // raw sensor readings and levels
  localparam int unsigned PCT_W     = 16;   // Q15 percentages
  localparam int unsigned CTRL_W    = 3;    // check control register
  localparam int unsigned CFG_IDX_W = 3;    // configuration register index
  localparam int unsigned ERR_W     = 2;
  localparam int unsigned TYPE_W    = 2;

  // Reciprocal of the span: 2^30 / (high - low), up to 31 quotient bits.
  localparam int unsigned QUO_W     = 31;
  localparam logic [QUO_W-1:0] MAP_NUMERATOR = 31'h4000_0000;
  localparam int unsigned PROD_W    = QUO_W + VAL_W;
  localparam int unsigned MAP_SHIFT = 15;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_S1_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_S1_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_S2_LOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_S2_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAULT_MAX = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FAULT_MIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VERIFY    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_CTL = 3'd7;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_S1_FAIL  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_S2_FAIL  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_DISAGREE = 2'd3;

  // Second sensor check types (bits 2:1 of check control).
  localparam logic [TYPE_W-1:0] TYPE_COPY     = 2'd0;
  localparam logic [TYPE_W-1:0] TYPE_DIRECT   = 2'd1;
  localparam logic [TYPE_W-1:0] TYPE_INVERT   = 2'd2;
  localparam logic [TYPE_W-1:0] TYPE_COPY_ALT = 2'd3;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] reg_index;
    logic [VAL_W-1:0]     wr_data;
  } cfg_wr_t;

  typedef struct packed {
    logic [VAL_W-1:0]  s1_low_level;
    logic [VAL_W-1:0]  s1_high_level;
    logic [VAL_W-1:0]  s2_low_level;
    logic [VAL_W-1:0]  s2_high_level;
    logic [VAL_W-1:0]  fault_max_level;
    logic [VAL_W-1:0]  fault_min_level;
    logic [VAL_W-1:0]  verify_range;
    logic [CTRL_W-1:0] check_control;
  } cfg_regs_t;

  typedef struct packed {
    logic [VAL_W-1:0] sample_one;
    logic [VAL_W-1:0] sample_two;
    logic             io_select;
  } in_item_t;

  typedef struct packed {
    logic [PCT_W-1:0] throttle_out;
    logic [ERR_W-1:0] error_code;
    logic [PCT_W-1:0] deviation;
    logic [VAL_W-1:0] excess_one;
    logic [VAL_W-1:0] excess_two;
  } out_item_t;

  // A reading is healthy inside [min, max]. With a nonzero check type the
  // select flag picks between "below min" and "inside the range".
  function automatic logic is_healthy(input logic [VAL_W-1:0]  x,
                                      input logic [VAL_W-1:0]  min_lvl,
                                      input logic [VAL_W-1:0]  max_lvl,
                                      input logic              io_sel,
                                      input logic [TYPE_W-1:0] chk_type);
    logic in_range;
    in_range = (x <= max_lvl) && (x >= min_lvl);
    if (chk_type != TYPE_COPY) begin
      return ((x < min_lvl) && !io_sel) || (in_range && io_sel);
    end
    return in_range;
  endfunction

  function automatic logic [VAL_W-1:0] excess_of(input logic [VAL_W-1:0] x,
                                                 input logic [VAL_W-1:0] min_lvl,
                                                 input logic [VAL_W-1:0] max_lvl);
    if (x > max_lvl) begin
      return x - max_lvl;
    end
    if (min_lvl > x) begin
      return min_lvl - x;
    end
    return '0;
  endfunction

  function automatic logic [PCT_W-1:0] abs_diff(input logic [PCT_W-1:0] a,
                                                input logic [PCT_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

### sv/dspm_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual sensor pedal map check - valid/ready channel
// One item moves at a clock edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface dspm_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

### sv/dual_sensor_pedal_map_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual sensor pedal map check - top level
// Plausibility check for a pedal with two position sensors: range checks,
// Q15 mapping through a shared reciprocal divider and one multiplier, and
// comparison of the two mapped values.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                                        Ready
//   cfg_if    in         reg_index, wr_data                             always
//   in_if     in         sample_one, sample_two, io_select              when idle
//   out_if    out        throttle_out, error_code, deviation,           -
//                        excess_one, excess_two
//
// An item occupies the block from acceptance to the next acceptance. When
// sensor 1 fails its range check the item goes straight to the final write;
// each mapping that needs a division waits on the 31-step bit-serial
// divider, then passes through a multiply, a saturate and a store state.
// A reading at or outside its map levels skips the divider.
// Reset clears the configuration registers and the held percentages and
// excess values. A result waits in the output register; the next item is
// taken meanwhile and only its final write waits for the register to drain.
//
module dual_sensor_pedal_map_check #(
  parameter int unsigned FULL_SCALE = 32768
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dspm_stream_if.sink   cfg_if,
  dspm_stream_if.sink   in_if,
  dspm_stream_if.source out_if
);
  import dspm_pkg::*;

  localparam logic [PCT_W-1:0] FullScale = PCT_W'(FULL_SCALE);
  localparam logic [PROD_W-MAP_SHIFT-1:0] FullScaleWide = (PROD_W-MAP_SHIFT)'(FULL_SCALE);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_SAT   = 3'd4;
  localparam logic [2:0] ST_POST  = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  cfg_regs_t cfg;

  dspm_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_if.valid),
    .wr_ready_o (cfg_if.ready),
    .wr_i       (cfg_if.payload),
    .regs_o     (cfg)
  );

  // Control state.
  logic [2:0] state_q, state_d;
  logic       sel_q, sel_d;          // 0 works on sensor 1, 1 on sensor 2
  logic       out_valid_q, out_valid_d;

  // Held state of the check.
  logic [PCT_W-1:0] p1_q, p1_d;
  logic [PCT_W-1:0] p2_q, p2_d;
  logic [VAL_W-1:0] exc1_q, exc1_d;
  logic [VAL_W-1:0] exc2_q, exc2_d;

  // Working registers of the current item.
  logic [VAL_W-1:0]  x1_q, x1_d;
  logic [VAL_W-1:0]  x2_q, x2_d;
  logic              io_q, io_d;
  logic [ERR_W-1:0]  err_q, err_d;
  logic [PCT_W-1:0]  pct_q, pct_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  out_item_t         out_q, out_d;

  // Shared divider.
  logic             div_start;
  logic             div_done;
  logic [QUO_W-1:0] quot;

  // Operands of the sensor now in work.
  logic [VAL_W-1:0]  cur_x, cur_lo, cur_hi;
  logic              cur_ok;
  logic [TYPE_W-1:0] chk_type;
  logic              chk_en;
  logic [PCT_W-1:0]  p2_new;
  logic              in_fire;

  assign chk_en   = cfg.check_control[0];
  assign chk_type = cfg.check_control[2:1];
  assign cur_x    = sel_q ? x2_q : x1_q;
  assign cur_lo   = sel_q ? cfg.s2_low_level  : cfg.s1_low_level;
  assign cur_hi   = sel_q ? cfg.s2_high_level : cfg.s1_high_level;
  assign cur_ok   = is_healthy(cur_x, cfg.fault_min_level, cfg.fault_max_level,
                               io_q, chk_type);

  dspm_divider u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (cur_hi - cur_lo),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  assign in_if.ready    = (state_q == ST_IDLE);
  assign in_fire        = in_if.valid && in_if.ready;
  assign out_if.valid   = out_valid_q;
  assign out_if.payload = out_q;

  // Sensor 2 value after the check type is applied.
  always_comb begin
    case (chk_type)
      TYPE_DIRECT: p2_new = pct_q;
      TYPE_INVERT: p2_new = FullScale - pct_q;
      default:     p2_new = p1_q;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    sel_d       = sel_q;
    out_valid_d = out_valid_q;
    p1_d        = p1_q;
    p2_d        = p2_q;
    exc1_d      = exc1_q;
    exc2_d      = exc2_q;
    x1_d        = x1_q;
    x2_d        = x2_q;
    io_d        = io_q;
    err_d       = err_q;
    pct_d       = pct_q;
    prod_d      = prod_q;
    out_d       = out_q;
    div_start   = 1'b0;

    if (out_valid_q && out_if.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          x1_d    = in_if.payload.sample_one;
          x2_d    = in_if.payload.sample_two;
          io_d    = in_if.payload.io_select;
          err_d   = ERR_NONE;
          sel_d   = 1'b0;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!cur_ok) begin
          // A failed range check records how far the reading is out.
          if (sel_q) begin
            err_d  = ERR_S2_FAIL;
            exc2_d = excess_of(x2_q, cfg.fault_min_level, cfg.fault_max_level);
          end else begin
            err_d  = ERR_S1_FAIL;
            exc1_d = excess_of(x1_q, cfg.fault_min_level, cfg.fault_max_level);
          end
          state_d = ST_FIN;
        end else if (sel_q && !(chk_type inside {TYPE_DIRECT, TYPE_INVERT})) begin
          // Copy types take sensor 1's value, so no mapping is needed.
          state_d = ST_POST;
        end else if (cur_x <= cur_lo) begin
          pct_d   = '0;
          state_d = ST_POST;
        end else if (cur_x >= cur_hi) begin
          pct_d   = FullScale;
          state_d = ST_POST;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d  = {{VAL_W{1'b0}}, quot} * {{QUO_W{1'b0}}, VAL_W'(cur_x - cur_lo)};
        state_d = ST_SAT;
      end
      ST_SAT: begin
        if (prod_q[PROD_W-1:MAP_SHIFT] > FullScaleWide) begin
          pct_d = FullScale;
        end else begin
          pct_d = prod_q[MAP_SHIFT+PCT_W-1:MAP_SHIFT];
        end
        state_d = ST_POST;
      end
      ST_POST: begin
        if (!sel_q) begin
          p1_d = pct_q;
          if (chk_en) begin
            sel_d   = 1'b1;
            state_d = ST_CHECK;
          end else begin
            state_d = ST_FIN;
          end
        end else begin
          p2_d = p2_new;
          if (abs_diff(p1_q, p2_new) > cfg.verify_range) begin
            err_d = ERR_DISAGREE;
          end
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_if.ready) begin
          out_d.throttle_out = (err_q == ERR_S1_FAIL) ? '0 : p1_q;
          out_d.error_code   = err_q;
          out_d.deviation    = abs_diff(p1_q, p2_q);
          out_d.excess_one   = exc1_q;
          out_d.excess_two   = exc2_q;
          out_valid_d        = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
      p1_q        <= '0;
      p2_q        <= '0;
      exc1_q      <= '0;
      exc2_q      <= '0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
      p1_q        <= p1_d;
      p2_q        <= p2_d;
      exc1_q      <= exc1_d;
      exc2_q      <= exc2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q   <= x1_d;
    x2_q   <= x2_d;
    io_q   <= io_d;
    err_q  <= err_d;
    pct_q  <= pct_d;
    prod_q <= prod_d;
    out_q  <= out_d;
  end

endmodule

### sv/dspm_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual sensor pedal map check - configuration registers
// Register file written over the configuration channel, always ready.
// ----------------------------------------------------------------------------
module dspm_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_valid_i,
  output logic               wr_ready_o,
  input  dspm_pkg::cfg_wr_t  wr_i,
  output dspm_pkg::cfg_regs_t regs_o
);
  import dspm_pkg::*;

  cfg_regs_t regs_q, regs_d;

  assign wr_ready_o = 1'b1;
  assign regs_o     = regs_q;

  always_comb begin
    regs_d = regs_q;
    if (wr_valid_i) begin
      case (wr_i.reg_index)
        REG_S1_LOW:    regs_d.s1_low_level    = wr_i.wr_data;
        REG_S1_HIGH:   regs_d.s1_high_level   = wr_i.wr_data;
        REG_S2_LOW:    regs_d.s2_low_level    = wr_i.wr_data;
        REG_S2_HIGH:   regs_d.s2_high_level   = wr_i.wr_data;
        REG_FAULT_MAX: regs_d.fault_max_level = wr_i.wr_data;
        REG_FAULT_MIN: regs_d.fault_min_level = wr_i.wr_data;
        REG_VERIFY:    regs_d.verify_range    = wr_i.wr_data;
        REG_CHECK_CTL: regs_d.check_control   = wr_i.wr_data[CTRL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= '0;
    end else begin
      regs_q <= regs_d;
    end
  end

endmodule

### sv/dspm_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual sensor pedal map check - reciprocal divider
// Restoring divider, one quotient bit per cycle, computing 2^30 / divisor.
// ----------------------------------------------------------------------------
module dspm_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [dspm_pkg::VAL_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [dspm_pkg::QUO_W-1:0] quot_o
);
  import dspm_pkg::*;

  localparam int unsigned CntW = $clog2(QUO_W);
  localparam logic [CntW-1:0] LastStep = CntW'(QUO_W - 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [VAL_W-1:0] div_q, div_d;
  logic [VAL_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0] quo_q, quo_d;

  logic [VAL_W:0] rem_sh;
  logic           fits;

  // The dividend shifts out of the top of the quotient register while
  // quotient bits shift in at the bottom.
  assign rem_sh = {rem_q, quo_q[QUO_W-1]};
  assign fits   = rem_sh >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    div_d  = div_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      div_d  = divisor_i;
      rem_d  = '0;
      quo_d  = MAP_NUMERATOR;
    end else if (busy_q) begin
      rem_d = fits ? VAL_W'(rem_sh - {1'b0, div_q}) : rem_sh[VAL_W-1:0];
      quo_d = {quo_q[QUO_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

### test/pedal_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pedal map check - result checker
// Watches the configuration, sample and result channels, keeps its own copy of
// the registers and the held pedal state, predicts one result for every sample
// item and compares each result item field by field with the oldest forecast.
// ----------------------------------------------------------------------------
module pedal_result_checker #(
  parameter int unsigned FULL_SCALE = 32768
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dspm_stream_if      cfg_mon,
  dspm_stream_if      in_mon,
  dspm_stream_if      out_mon,
  output int unsigned pending_o,
  output int unsigned mismatches_o
);
  import dspm_pkg::*;

  cfg_regs_t        regs;
  logic [PCT_W-1:0] pct_one;
  logic [PCT_W-1:0] pct_two;
  logic [VAL_W-1:0] over_one;
  logic [VAL_W-1:0] over_two;
  out_item_t        expected_results[$];
  int unsigned      mismatch_total;

  function automatic logic reading_ok(input logic [VAL_W-1:0]  x,
                                      input logic              io,
                                      input logic [TYPE_W-1:0] kind);
    logic in_window;
    in_window = (x <= regs.fault_max_level) && (x >= regs.fault_min_level);
    if (kind != TYPE_COPY) begin
      return ((x < regs.fault_min_level) && !io) || (in_window && io);
    end
    return in_window;
  endfunction

  function automatic logic [VAL_W-1:0] overshoot(input logic [VAL_W-1:0] x);
    if (x > regs.fault_max_level) begin
      return x - regs.fault_max_level;
    end
    if (regs.fault_min_level > x) begin
      return regs.fault_min_level - x;
    end
    return '0;
  endfunction

  function automatic logic [PCT_W-1:0] pct_gap(input logic [PCT_W-1:0] a,
                                               input logic [PCT_W-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Q15 position: reciprocal of the span, times the offset, dropped by 15 bits.
  function automatic logic [PCT_W-1:0] to_percent(input logic [VAL_W-1:0] lo,
                                                  input logic [VAL_W-1:0] hi,
                                                  input logic [VAL_W-1:0] x);
    logic [31:0] recip;
    logic [63:0] scaled;
    if (x <= lo) begin
      return '0;
    end
    if (x >= hi) begin
      return PCT_W'(FULL_SCALE);
    end
    recip  = 32'h4000_0000 / {16'd0, VAL_W'(hi - lo)};
    scaled = ({32'd0, recip} * {48'd0, VAL_W'(x - lo)}) >> MAP_SHIFT;
    if (scaled > 64'(FULL_SCALE)) begin
      scaled = 64'(FULL_SCALE);
    end
    return scaled[PCT_W-1:0];
  endfunction

  function automatic out_item_t pedal_outcome(input in_item_t it);
    out_item_t        r;
    logic [TYPE_W-1:0] kind;
    kind = regs.check_control[2:1];
    r    = '0;
    r.error_code = ERR_NONE;
    if (reading_ok(it.sample_one, it.io_select, kind)) begin
      pct_one = to_percent(regs.s1_low_level, regs.s1_high_level, it.sample_one);
      if (regs.check_control[0]) begin
        if (reading_ok(it.sample_two, it.io_select, kind)) begin
          pct_two = to_percent(regs.s2_low_level, regs.s2_high_level, it.sample_two);
          if (kind == TYPE_INVERT) begin
            pct_two = PCT_W'(FULL_SCALE) - pct_two;
          end else if (kind != TYPE_DIRECT) begin
            pct_two = pct_one;
          end
          if (pct_gap(pct_one, pct_two) > regs.verify_range) begin
            r.error_code = ERR_DISAGREE;
          end
        end else begin
          r.error_code = ERR_S2_FAIL;
          over_two     = overshoot(it.sample_two);
        end
      end
      r.throttle_out = pct_one;
    end else begin
      r.error_code = ERR_S1_FAIL;
      over_one     = overshoot(it.sample_one);
    end
    r.deviation  = pct_gap(pct_one, pct_two);
    r.excess_one = over_one;
    r.excess_two = over_two;
    return r;
  endfunction

  task automatic take_register(input cfg_wr_t w);
    case (w.reg_index)
      REG_S1_LOW:    regs.s1_low_level    = w.wr_data;
      REG_S1_HIGH:   regs.s1_high_level   = w.wr_data;
      REG_S2_LOW:    regs.s2_low_level    = w.wr_data;
      REG_S2_HIGH:   regs.s2_high_level   = w.wr_data;
      REG_FAULT_MAX: regs.fault_max_level = w.wr_data;
      REG_FAULT_MIN: regs.fault_min_level = w.wr_data;
      REG_VERIFY:    regs.verify_range    = w.wr_data;
      REG_CHECK_CTL: regs.check_control   = w.wr_data[CTRL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      mismatch_total++;
      if (mismatch_total <= 10) begin
        $display("%0t: %s expected %h, got %h", $time, what, want, got);
      end
    end
  endtask

  task automatic compare_result(input out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      mismatch_total++;
      if (mismatch_total <= 10) begin
        $display("%0t: result item %h arrived with none expected", $time, got);
      end
    end else begin
      want = expected_results.pop_front();
      check_field("throttle_out", want.throttle_out, got.throttle_out);
      check_field("error_code", 16'(want.error_code), 16'(got.error_code));
      check_field("deviation", want.deviation, got.deviation);
      check_field("excess_one", want.excess_one, got.excess_one);
      check_field("excess_two", want.excess_two, got.excess_two);
    end
  endtask

  initial begin
    mismatch_total = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs     = '0;
      pct_one  = '0;
      pct_two  = '0;
      over_one = '0;
      over_two = '0;
      expected_results.delete();
      pending_o    <= 0;
      mismatches_o <= mismatch_total;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        take_register(cfg_mon.payload);
      end
      // Results are compared before a new forecast is queued, so a stray
      // result can never be matched against an item accepted at this edge.
      if (out_mon.valid && out_mon.ready) begin
        compare_result(out_mon.payload);
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_results.push_back(pedal_outcome(in_mon.payload));
      end
      pending_o    <= expected_results.size();
      mismatches_o <= mismatch_total;
    end
  end

endmodule

### test/tb_dual_sensor_pedal_map_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pedal map check - testbench top
// Drives register writes and pedal sample items into the block, applies random
// back pressure on the result channel and reports the verdict. Prediction and
// comparison live in the result checker instantiated beside the block.
// ----------------------------------------------------------------------------
module tb_dual_sensor_pedal_map_check;
  import dspm_pkg::*;

  localparam int unsigned FULL_SCALE = 32768;

  // A slow item plus a long receiver stall still stays far below the point
  // where the watchdog gives up.
  localparam int unsigned STALL_LIMIT   = 5000;
  // Quiet time after the last result, a bit more than the longest item.
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned PHASES        = 36;
  localparam int unsigned PHASE_ITEMS   = 43;

  logic        clk_i;
  logic        rst_ni;
  int unsigned pending;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  // Idle percentages of the sample sender and of the result receiver, and
  // the remaining length of a stretch without any idling on each side.
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned tx_calm;
  int unsigned rx_calm;

  // Copy of the last written registers, used only to aim the stimulus.
  cfg_regs_t live_cfg;

  dspm_stream_if #(.payload_t(cfg_wr_t))   cfg_ch ();
  dspm_stream_if #(.payload_t(in_item_t))  in_ch ();
  dspm_stream_if #(.payload_t(out_item_t)) out_ch ();

  dual_sensor_pedal_map_check #(
    .FULL_SCALE (FULL_SCALE)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_if (cfg_ch),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  pedal_result_checker #(
    .FULL_SCALE (FULL_SCALE)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_mon      (cfg_ch),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .pending_o    (pending),
    .mismatches_o (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // The result receiver: ready is redrawn every cycle, with occasional
  // stretches where it stays high throughout.
  always @(posedge clk_i) begin
    if (rx_calm > 0) begin
      rx_calm      <= rx_calm - 1;
      out_ch.ready <= 1'b1;
    end else begin
      if ($urandom_range(99) < 2) begin
        rx_calm <= $urandom_range(40, 10);
      end
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: any accepted item on any channel restarts the count. A result
  // that never comes therefore ends the run here.
  always @(posedge clk_i) begin
    if (!rst_ni || (cfg_ch.valid && cfg_ch.ready) || (in_ch.valid && in_ch.ready) ||
        (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_dual_sensor_pedal_map_check: done, errors");
      $finish;
    end
  end

  // Number of idle cycles before the next sample item. Draws are geometric,
  // so short gaps dominate but longer ones still show up.
  function automatic int unsigned tx_gap();
    int unsigned n;
    n = 0;
    if (tx_calm > 0) begin
      tx_calm--;
      return 0;
    end
    if ($urandom_range(99) < 3) begin
      tx_calm = $urandom_range(40, 10);
    end
    while (n < 50 && $urandom_range(99) < tx_idle_pct) begin
      n++;
    end
    return n;
  endfunction

  // Offers one sample item and returns at the edge where it is taken. Valid
  // is only lowered when a gap follows, so it never toggles within one step.
  task automatic push_sample(input in_item_t it);
    int unsigned gap;
    gap = tx_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Stops the sample stream and waits until every forecast has been matched.
  // The first edge lets the checker count an item taken at the current edge.
  task automatic drain_results(input int unsigned linger);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (linger) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.payload <= '{reg_index: idx, wr_data: data};
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  // Registers are only written once the block has gone idle; all eight are
  // written every time.
  task automatic load_settings(input logic [VAL_W-1:0] lo1, input logic [VAL_W-1:0] hi1,
                               input logic [VAL_W-1:0] lo2, input logic [VAL_W-1:0] hi2,
                               input logic [VAL_W-1:0] mx,  input logic [VAL_W-1:0] mn,
                               input logic [VAL_W-1:0] vr,  input logic [CTRL_W-1:0] ctl);
    drain_results(SETTLE_CYCLES);
    write_reg(REG_S1_LOW, lo1);
    write_reg(REG_S1_HIGH, hi1);
    write_reg(REG_S2_LOW, lo2);
    write_reg(REG_S2_HIGH, hi2);
    write_reg(REG_FAULT_MAX, mx);
    write_reg(REG_FAULT_MIN, mn);
    write_reg(REG_VERIFY, vr);
    write_reg(REG_CHECK_CTL, VAL_W'(ctl));
    cfg_ch.valid <= 1'b0;
    live_cfg = '{s1_low_level: lo1, s1_high_level: hi1, s2_low_level: lo2,
                 s2_high_level: hi2, fault_max_level: mx, fault_min_level: mn,
                 verify_range: vr, check_control: ctl};
  endtask

  task automatic send(input logic [VAL_W-1:0] x1, input logic [VAL_W-1:0] x2,
                      input logic io);
    push_sample('{sample_one: x1, sample_two: x2, io_select: io});
  endtask

  // Random registers. Map spans come in small, medium and wide sizes, with a
  // share of empty or reversed spans; the healthy window usually brackets the
  // map levels so that most readings get through the range check.
  task automatic random_settings();
    int          span;
    int          lo1, hi1, lo2, hi2, mn, mx, vr, lo_all, hi_all;
    logic [2:0]  ctl;
    case ($urandom_range(9))
      0, 1, 2: span = $urandom_range(16, 1);
      3, 4, 5: span = $urandom_range(4096, 17);
      6, 7, 8: span = $urandom_range(65535, 4097);
      default: span = 0;
    endcase
    if (span > 0) begin
      lo1 = $urandom_range(65535 - span, 0);
      hi1 = lo1 + span;
    end else begin
      lo1 = $urandom_range(65535, 0);
      hi1 = $urandom_range(lo1, 0);
    end
    if (span > 0 && $urandom_range(99) < 60) begin
      lo2 = $urandom_range(65535 - span, 0);
      hi2 = lo2 + span;
    end else begin
      lo2 = $urandom_range(65535, 0);
      hi2 = $urandom_range(65535, 0);
    end
    lo_all = lo1;
    if (hi1 < lo_all) lo_all = hi1;
    if (lo2 < lo_all) lo_all = lo2;
    if (hi2 < lo_all) lo_all = hi2;
    hi_all = lo1;
    if (hi1 > hi_all) hi_all = hi1;
    if (lo2 > hi_all) hi_all = lo2;
    if (hi2 > hi_all) hi_all = hi2;
    case ($urandom_range(9))
      7, 8: begin
        mn = $urandom_range(65535, 0);
        mx = $urandom_range(65535, 0);
      end
      9: begin
        mn = 0;
        mx = 65535;
      end
      default: begin
        mn = lo_all - int'($urandom_range(256, 0));
        mx = hi_all + int'($urandom_range(256, 0));
        if (mn < 0) mn = 0;
        if (mx > 65535) mx = 65535;
      end
    endcase
    case ($urandom_range(9))
      0, 1, 2, 3: vr = $urandom_range(512, 0);
      4, 5:       vr = $urandom_range(32768, 0);
      6:          vr = 0;
      7:          vr = 32768;
      default:    vr = $urandom_range(4096, 0);
    endcase
    ctl = 3'($urandom_range(7, 0));
    if ($urandom_range(99) < 80) begin
      ctl[0] = 1'b1;
    end
    load_settings(16'(lo1), 16'(hi1), 16'(lo2), 16'(hi2), 16'(mx), 16'(mn), 16'(vr), ctl);
  endtask

  // One raw reading, aimed at the healthy window, the map span, the edges of
  // both, the region below the minimum, the two extremes, or anywhere at all.
  function automatic logic [VAL_W-1:0] pick_reading(input int lo, input int hi);
    int mn, mx;
    mn = live_cfg.fault_min_level;
    mx = live_cfg.fault_max_level;
    case ($urandom_range(9))
      2, 3: return (mn <= mx) ? 16'($urandom_range(mx, mn)) : 16'($urandom_range(65535, 0));
      4, 5: return 16'($urandom_range(hi, lo));
      6: begin
        case ($urandom_range(9))
          0: return 16'(mn - 1);
          1: return 16'(mn);
          2: return 16'(mn + 1);
          3: return 16'(mx - 1);
          4: return 16'(mx);
          5: return 16'(mx + 1);
          6: return 16'(lo);
          7: return 16'(lo + 1);
          8: return 16'(hi - 1);
          default: return 16'(hi);
        endcase
      end
      7: return (mn > 0) ? 16'($urandom_range(mn - 1, 0)) : 16'h0000;
      8: return $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom_range(65535, 0));
    endcase
  endfunction

  // A random sample item. With a nonzero check type the select flag mostly
  // matches the reading, so that sensor 1 passes and the sensor 2 path is
  // reached. Half of the time sensor 2 tracks sensor 1 through the second
  // map, directly or mirrored, so the comparison lands near the verify range.
  function automatic in_item_t make_sample();
    in_item_t          it;
    logic [TYPE_W-1:0] kind;
    int                off, v;
    kind = live_cfg.check_control[2:1];
    it.sample_one = pick_reading(live_cfg.s1_low_level, live_cfg.s1_high_level);
    if (kind != TYPE_COPY && $urandom_range(99) < 80) begin
      it.io_select = (it.sample_one < live_cfg.fault_min_level) ? 1'b0 : 1'b1;
    end else begin
      it.io_select = 1'($urandom_range(1, 0));
    end
    if ($urandom_range(1, 0) == 1) begin
      off = int'(it.sample_one) - int'(live_cfg.s1_low_level);
      if (kind == TYPE_INVERT) begin
        v = int'(live_cfg.s2_high_level) - off;
      end else begin
        v = int'(live_cfg.s2_low_level) + off;
      end
      v = v + int'($urandom_range(64, 0)) - 32;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      it.sample_two = 16'(v);
    end else begin
      it.sample_two = pick_reading(live_cfg.s2_low_level, live_cfg.s2_high_level);
    end
    return it;
  endfunction

  initial begin
    rst_ni         = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.payload = '0;
    in_ch.valid    = 1'b0;
    in_ch.payload  = '0;
    out_ch.ready   = 1'b0;
    quiet_cycles   = 0;
    tx_calm        = 0;
    rx_calm        = 0;
    tx_idle_pct    = 34;
    rx_idle_pct    = 70;
    live_cfg       = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers straight out of reset: a zero-width window at zero and a
    // zero map span, with the second sensor check off.
    send(16'h0000, 16'h0000, 1'b0);
    send(16'hFFFF, 16'hFFFF, 1'b1);

    // Full-width maps, direct comparison, no tolerance. The select flag set
    // to zero demands a reading below a minimum of zero, which cannot pass.
    load_settings(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
                  {TYPE_DIRECT, 1'b1});
    send(16'h0000, 16'hFFFF, 1'b1);
    send(16'hFFFF, 16'h0000, 1'b1);
    send(16'h8000, 16'h8000, 1'b1);
    send(16'h8000, 16'h8001, 1'b1);
    send(16'h1234, 16'h1234, 1'b0);

    // Inverted comparison with the widest tolerance; readings below the
    // minimum count as healthy when the select flag is low.
    load_settings(16'h1000, 16'hF000, 16'h1000, 16'hF000, 16'hF000, 16'h1000, 16'h8000,
                  {TYPE_INVERT, 1'b1});
    send(16'h0FFF, 16'hF001, 1'b0);
    send(16'h0800, 16'h0001, 1'b0);
    send(16'h8000, 16'h8000, 1'b1);
    send(16'hF000, 16'h1000, 1'b1);
    send(16'hFFFF, 16'h8000, 1'b1);

    // Reversed and empty map spans, with sensor 2 copied from sensor 1.
    load_settings(16'hFFFF, 16'h0000, 16'h8000, 16'h8000, 16'hFFFF, 16'h0000, 16'h0000,
                  {TYPE_COPY, 1'b1});
    send(16'hFFFF, 16'h1234, 1'b1);
    send(16'h0000, 16'h8000, 1'b0);

    // The narrowest spans that still divide, and the second copy type.
    load_settings(16'h0100, 16'h0102, 16'h0100, 16'h0102, 16'hFFAF, 16'h0050, 16'h0001,
                  {TYPE_COPY_ALT, 1'b1});
    send(16'h0101, 16'h0101, 1'b1);
    send(16'h0101, 16'h0010, 1'b0);
    send(16'h0040, 16'hFFFF, 1'b0);

    // Every map and window level at its top value, second sensor check switched off.
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000,
                  {TYPE_INVERT, 1'b0});
    send(16'hFFFF, 16'h0000, 1'b1);
    send(16'h0000, 16'h0000, 1'b0);
    send(16'hFFFE, 16'h0000, 1'b1);

    // Random phases: a third with a slow receiver, a third with a slow
    // sender, and a third at full rate. Now and then the sender also holds
    // off until every result is out, so the block starts from idle.
    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES / 3) begin
        tx_idle_pct = 70;
        rx_idle_pct = 34;
      end else if (p == 2 * PHASES / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      random_settings();
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(99) < 3) begin
          drain_results(0);
        end
        push_sample(make_sample());
      end
    end

    drain_results(SETTLE_CYCLES);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_dual_sensor_pedal_map_check: done, clean");
    end else begin
      $display("tb_dual_sensor_pedal_map_check: done, errors");
    end
    $finish;
  end

endmodule
